// ----- rtl/bis_pkg.sv -----
// package for the bounded integer sequence store
// operation codes, cell control types and shared constants; no dependencies
`default_nettype none
package bis_pkg;

  localparam int unsigned DefDepth = 256;
  localparam int unsigned PosW     = 16;
  localparam int unsigned CntW     = 17;
  localparam int unsigned ValW     = 32;
  localparam int unsigned OutCntW  = 9;

  localparam logic [2:0] OpRead   = 3'd0;
  localparam logic [2:0] OpAppend = 3'd1;
  localparam logic [2:0] OpDrop   = 3'd2;
  localparam logic [2:0] OpFind   = 3'd3;
  localparam logic [2:0] OpWrite  = 3'd4;
  localparam logic [2:0] OpRemove = 3'd5;

  typedef enum logic [1:0] {
    CM_HOLD  = 2'd0,
    CM_ROT   = 2'd1,
    CM_WRITE = 2'd2,
    CM_SHIFT = 2'd3
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e        mode;
    logic [PosW-1:0]   pos;
    logic [CntW-1:0]   cnt;
    logic [ValW-1:0]   val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/bis_cell.sv -----
// one storage cell of the sequence store chain
// depends on bis_pkg for the control struct
`default_nettype none
module bis_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                     clk_i,
  input  bis_pkg::cell_ctrl_t      ctrl_i,
  input  logic [bis_pkg::ValW-1:0] nbr_i,
  output logic [bis_pkg::ValW-1:0] q_o
);
  import bis_pkg::*;

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic [ValW-1:0] data_q;
  logic [CntW-1:0] pos_ext;

  assign pos_ext = CntW'(ctrl_i.pos);
  assign q_o     = data_q;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.mode)
      CM_ROT: data_q <= nbr_i;
      CM_WRITE: begin
        if (IdxC == pos_ext) begin
          data_q <= ctrl_i.val;
        end else if (IdxC >= ctrl_i.cnt && IdxC < pos_ext) begin
          data_q <= '0;
        end
      end
      CM_SHIFT: begin
        if (IdxC >= pos_ext) begin
          data_q <= nbr_i;
        end
      end
      default: data_q <= data_q;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/bounded_int_sequence_store_top.sv -----
// top level of the bounded integer sequence store
// depends on bis_pkg and bis_cell
`default_nettype none
// Keeps an ordered list of up to DEPTH signed 32-bit values in a chain of
// cells. Append, drop, write (with zero fill) and remove need no rotation:
// the result strobe follows the accepting edge. Read and find rotate the
// whole chain once past the head cell and register the result after the
// rotation; busy_o is high during that rotation. Every transaction gives
// exactly one result, shown for one cycle on done_o; the receiver cannot stall.
module bounded_int_sequence_store_top #(
  parameter int unsigned DEPTH = bis_pkg::DefDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  operation_i,
  input  logic [bis_pkg::PosW-1:0]    position_i,
  input  logic signed [31:0]          operand_value_i,
  output logic                        done_o,
  output logic signed [31:0]          read_data_o,
  output logic signed [8:0]           found_position_o,
  output logic                        error_flag_o,
  output logic [8:0]                  element_count_o
);
  import bis_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [IW-1:0]   k_q, k_d;
  logic            done_q, done_d;
  logic            find_q;
  logic [PosW-1:0] pos_q;
  logic [ValW-1:0] val_q, cap_q;
  logic [ValW-1:0] rd_q, rd_d;
  logic [8:0]      fp_q, fp_d;
  logic            err_q, err_d;

  cell_ctrl_t      ctrl;
  logic [ValW-1:0] cell_q [DEPTH];
  logic            accept;
  logic [CntW-1:0] cnt_ext, pos_ext, k_ext;
  logic [ValW-1:0] head;
  logic            last;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign cnt_ext = CntW'(count_q);
  assign pos_ext = CntW'(position_i);
  assign k_ext   = CntW'(k_q);
  assign head    = cell_q[0];
  assign last    = (k_q == IW'(DEPTH - 1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bis_cell #(.Idx(i)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .nbr_i  (cell_q[(i + 1) % DEPTH]),
      .q_o    (cell_q[i])
    );
  end

  always_comb begin
    ctrl.mode = CM_HOLD;
    ctrl.pos  = position_i;
    ctrl.cnt  = cnt_ext;
    ctrl.val  = operand_value_i;
    state_d   = state_q;
    count_d   = count_q;
    k_d       = k_q;
    done_d    = 1'b0;
    rd_d      = rd_q;
    fp_d      = fp_q;
    err_d     = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_d  = '0;
          fp_d  = '1;
          err_d = 1'b0;
          case (operation_i)
            OpRead, OpFind: begin
              state_d = ST_SCAN;
              k_d     = '0;
            end
            OpAppend: begin
              done_d = 1'b1;
              if (cnt_ext < DepthC) begin
                ctrl.mode = CM_WRITE;
                ctrl.pos  = PosW'(count_q);
                count_d   = count_q + 1'b1;
              end else begin
                err_d = 1'b1;
              end
            end
            OpDrop: begin
              done_d = 1'b1;
              if (count_q != '0) begin
                count_d = count_q - 1'b1;
              end else begin
                err_d = 1'b1;
              end
            end
            OpWrite: begin
              done_d = 1'b1;
              if (pos_ext < DepthC) begin
                ctrl.mode = CM_WRITE;
                if (pos_ext >= cnt_ext) begin
                  count_d = CW'(pos_ext + 1'b1);
                end
              end else begin
                err_d = 1'b1;
              end
            end
            OpRemove: begin
              done_d = 1'b1;
              if (pos_ext < cnt_ext) begin
                ctrl.mode = CM_SHIFT;
                count_d   = count_q - 1'b1;
              end else begin
                err_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        ctrl.mode = CM_ROT;
        k_d       = k_q + 1'b1;
        if (find_q && k_ext < cnt_ext && head == val_q) begin
          fp_d = 9'(k_q);
        end
        if (last) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          if (!find_q) begin
            if (CntW'(pos_q) < cnt_ext) begin
              rd_d = (k_ext == CntW'(pos_q)) ? head : cap_q;
            end else begin
              rd_d  = '1;
              err_d = 1'b1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= rd_d;
    fp_q  <= fp_d;
    err_q <= err_d;
    if (accept) begin
      find_q <= (operation_i == OpFind);
      pos_q  <= position_i;
      val_q  <= operand_value_i;
    end
    if (state_q == ST_SCAN && k_ext == CntW'(pos_q)) begin
      cap_q <= head;
    end
  end

  assign busy_o           = (state_q == ST_SCAN);
  assign done_o           = done_q;
  assign read_data_o      = rd_q;
  assign found_position_o = fp_q;
  assign error_flag_o     = err_q;
  assign element_count_o  = 9'(count_q);

endmodule
`default_nettype wire

// ----- rtl/bis_checker.sv -----
// port-level checker for the bounded integer sequence store
// depends on bis_pkg; bound to bounded_int_sequence_store_top
`default_nettype none
module bis_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [2:0]  operation_i,
  input logic        done_o,
  input logic [8:0]  found_position_o,
  input logic        error_flag_o
);
  import bis_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && operation_i != OpRead && operation_i != OpFind |=> done_o)
    else $error("single-cycle transaction gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && error_flag_o |-> found_position_o == 9'h1ff)
    else $error("refused transaction reports a found position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a transaction");

endmodule

bind bounded_int_sequence_store_top bis_checker u_bis_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .operation_i      (operation_i),
  .done_o           (done_o),
  .found_position_o (found_position_o),
  .error_flag_o     (error_flag_o)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for bounded_int_sequence_store_top: random and directed list requests
// checked against a behavioral list model; depends on bis_pkg and the rtl
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bis_pkg::*;

  localparam int unsigned Depth = DefDepth;

  typedef struct {
    logic [2:0]         op;
    logic [PosW-1:0]    pos;
    logic signed [31:0] val;
  } request_t;

  typedef struct {
    logic signed [31:0] rdata;
    logic signed [8:0]  fpos;
    logic               err;
    logic [8:0]         cnt;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [2:0] operation_i = '0;
  logic [PosW-1:0] position_i = '0;
  logic signed [31:0] operand_value_i = '0;
  logic busy_o, done_o, error_flag_o;
  logic signed [31:0] read_data_o;
  logic signed [8:0] found_position_o;
  logic [8:0] element_count_o;

  bounded_int_sequence_store_top #(.DEPTH(Depth)) i_dut (.*);

  always #5 clk_i = ~clk_i;

  request_t pending_q[$];
  reply_t expected_q[$];
  logic [31:0] list_mem[Depth];
  int unsigned list_len = 0;
  int errors = 0;
  bit hold_for_drain = 0;
  int unsigned items_sent = 0;

  function automatic reply_t apply_request(request_t r);
    reply_t y;
    y.rdata = '0; y.fpos = '1; y.err = 1'b0;
    case (r.op)
      OpRead:
        if (r.pos < list_len) y.rdata = list_mem[r.pos];
        else begin y.rdata = '1; y.err = 1'b1; end
      OpAppend:
        if (list_len < Depth) begin list_mem[list_len] = r.val; list_len++; end
        else y.err = 1'b1;
      OpDrop:
        if (list_len > 0) list_len--;
        else y.err = 1'b1;
      OpFind:
        for (int k = 0; k < list_len; k++) if (list_mem[k] == r.val) y.fpos = k[8:0];
      OpWrite:
        if (r.pos < Depth) begin
          if (r.pos >= list_len) begin
            for (int k = list_len; k < r.pos; k++) list_mem[k] = '0;
            list_len = r.pos + 1;
          end
          list_mem[r.pos] = r.val;
        end else y.err = 1'b1;
      OpRemove:
        if (r.pos < list_len) begin
          for (int k = r.pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end else y.err = 1'b1;
      default: ;
    endcase
    y.cnt = list_len[8:0];
    return y;
  endfunction

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_q.push_back(apply_request('{operation_i, position_i, operand_value_i}));
        items_sent++;
      end
      if (start_i && busy_o) begin
      end else if (hold_for_drain || pending_q.size() == 0 || gap_left > 0) begin
        start_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        request_t r;
        r = pending_q.pop_front();
        start_i <= 1'b1;
        operation_i <= r.op;
        position_i <= r.pos;
        operand_value_i <= r.val;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction rd=%0d fp=%0d err=%0b cnt=%0d", $realtime,
                 read_data_o, found_position_o, error_flag_o, element_count_o);
        errors++;
      end else begin
        reply_t e;
        e = expected_q.pop_front();
        if (read_data_o !== e.rdata) begin
          $display("%0t: read_data exp %0d got %0d", $realtime, e.rdata, read_data_o);
          errors++;
        end
        if (found_position_o !== e.fpos) begin
          $display("%0t: found_position exp %0d got %0d", $realtime, e.fpos, found_position_o);
          errors++;
        end
        if (error_flag_o !== e.err) begin
          $display("%0t: error_flag exp %0b got %0b", $realtime, e.err, error_flag_o);
          errors++;
        end
        if (element_count_o !== e.cnt) begin
          $display("%0t: element_count exp %0d got %0d", $realtime, e.cnt, element_count_o);
          errors++;
        end
      end
    end
  end

  function automatic request_t rand_request(int unsigned len_est);
    request_t r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) r.op = OpAppend;
    else if (sel < 40) r.op = OpDrop;
    else if (sel < 52) r.op = OpRead;
    else if (sel < 60) r.op = OpFind;
    else if (sel < 78) r.op = OpWrite;
    else if (sel < 96) r.op = OpRemove;
    else r.op = 3'($urandom_range(6, 7));
    case ($urandom_range(0, 9))
      0: r.pos = 16'($urandom());
      1: r.pos = 16'($urandom_range(0, Depth + 2));
      2: r.pos = len_est[15:0];
      default: r.pos = 16'($urandom_range(0, len_est + 1));
    endcase
    case ($urandom_range(0, 5))
      0: r.val = $urandom();
      1: r.val = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: r.val = $urandom_range(0, 15) - 8;
    endcase
    return r;
  endfunction

  task automatic push_req(logic [2:0] op, int unsigned pos, logic [31:0] val);
    pending_q.push_back('{op, pos[15:0], val});
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
    hold_for_drain = 1;
    while (start_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    hold_for_drain = 0;
  endtask

  initial begin
    int unsigned len_est;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    push_req(OpDrop, 0, 0);
    push_req(OpRead, 0, 0);
    push_req(OpRemove, 0, 0);
    push_req(OpFind, 0, 0);
    push_req(OpAppend, 0, 32'h80000000);
    push_req(OpAppend, 0, 32'h7fffffff);
    push_req(OpAppend, 0, 32'hffffffff);
    push_req(OpFind, 0, 32'h7fffffff);
    push_req(OpRead, 2, 0);
    push_req(OpRead, 3, 0);
    push_req(OpRead, 16'hffff, 0);
    push_req(OpWrite, 6, 32'h12345678);
    push_req(OpFind, 0, 0);
    push_req(OpRemove, 0, 0);
    push_req(OpRemove, 16'hffff, 0);
    push_req(OpWrite, Depth, 5);
    push_req(OpWrite, 16'hffff, 5);
    push_req(3'd6, 16'hffff, 32'hffffffff);
    push_req(3'd7, 0, 0);
    push_req(OpWrite, Depth - 1, 32'h55aa55aa);
    push_req(OpAppend, 0, 1);
    push_req(OpFind, 0, 0);
    push_req(OpRead, Depth - 1, 0);
    push_req(OpRemove, Depth - 1, 0);
    push_req(OpWrite, 0, 0);
    wait_drained();
    // shrink back to a small list
    for (int i = 0; i < 260; i++) push_req(OpDrop, 0, 0);
    wait_drained();
    len_est = 0;
    for (int i = 0; i < 1800; i++) begin
      request_t r;
      r = rand_request(len_est);
      pending_q.push_back(r);
      if (r.op == OpAppend && len_est < Depth) len_est++;
      if ((r.op == OpDrop || r.op == OpRemove) && len_est > 0) len_est--;
      if (r.op == OpWrite && r.pos >= len_est && r.pos < Depth) len_est = r.pos + 1;
      if (i % 300 == 299) begin
        wait_drained();
        len_est = list_len;
      end
    end
    wait_drained();
    repeat (Depth + 20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/bis_pkg.sv
rtl/bis_cell.sv
rtl/bounded_int_sequence_store_top.sv
rtl/bis_checker.sv
verif/tb_top.sv
